// ===== hw/rtl/ll1ep_pkg.sv =====
// ll1ep_pkg: symbol codes, result codes and grammar tables of the expression parser
// standalone package, imported by the parser core and its checker

package ll1ep_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;

    typedef enum logic [3:0] {
        SYM_END  = 4'd0,
        SYM_E    = 4'd1,
        SYM_EP   = 4'd2,
        SYM_T    = 4'd3,
        SYM_TP   = 4'd4,
        SYM_F    = 4'd5,
        SYM_ID   = 4'd6,
        SYM_PLUS = 4'd7,
        SYM_STAR = 4'd8,
        SYM_LP   = 4'd9,
        SYM_RP   = 4'd10,
        SYM_BAD  = 4'd15
    } t_sym;

    typedef enum logic [1:0] {
        VERDICT_BUSY   = 2'd0,
        VERDICT_ACCEPT = 2'd1,
        VERDICT_REJECT = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_MISMATCH = 2'd1,
        ERR_EMPTY    = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    // production in push order, last pushed symbol becomes the new top
    typedef struct packed {
        logic       ok;
        logic [1:0] len;
        t_sym       rhs0;
        t_sym       rhs1;
        t_sym       rhs2;
    } t_prod;

    function automatic t_sym classify(input logic [7:0] ch);
        t_sym s;
        if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
            s = SYM_ID;
        end else if (ch == CH_PLUS) begin
            s = SYM_PLUS;
        end else if (ch == CH_STAR) begin
            s = SYM_STAR;
        end else if (ch == CH_LP) begin
            s = SYM_LP;
        end else if (ch == CH_RP) begin
            s = SYM_RP;
        end else begin
            s = SYM_BAD;
        end
        return s;
    endfunction

    function automatic logic is_nonterm(input t_sym s);
        return (s == SYM_E) || (s == SYM_EP) || (s == SYM_T) || (s == SYM_TP) || (s == SYM_F);
    endfunction

    function automatic t_prod lookup(input t_sym nt, input t_sym tok);
        t_prod p;
        p = '{ok: 1'b0, len: 2'd0, rhs0: SYM_END, rhs1: SYM_END, rhs2: SYM_END};
        case (nt)
            SYM_E: begin
                if (tok == SYM_ID || tok == SYM_LP) begin
                    p = '{ok: 1'b1, len: 2'd2, rhs0: SYM_EP, rhs1: SYM_T, rhs2: SYM_END};
                end
            end
            SYM_EP: begin
                if (tok == SYM_PLUS) begin
                    p = '{ok: 1'b1, len: 2'd3, rhs0: SYM_EP, rhs1: SYM_T, rhs2: SYM_PLUS};
                end else if (tok == SYM_RP || tok == SYM_END) begin
                    p.ok = 1'b1;
                end
            end
            SYM_T: begin
                if (tok == SYM_ID || tok == SYM_LP) begin
                    p = '{ok: 1'b1, len: 2'd2, rhs0: SYM_TP, rhs1: SYM_F, rhs2: SYM_END};
                end
            end
            SYM_TP: begin
                if (tok == SYM_STAR) begin
                    p = '{ok: 1'b1, len: 2'd3, rhs0: SYM_TP, rhs1: SYM_F, rhs2: SYM_STAR};
                end else if (tok == SYM_PLUS || tok == SYM_RP || tok == SYM_END) begin
                    p.ok = 1'b1;
                end
            end
            SYM_F: begin
                if (tok == SYM_ID) begin
                    p = '{ok: 1'b1, len: 2'd1, rhs0: SYM_ID, rhs1: SYM_END, rhs2: SYM_END};
                end else if (tok == SYM_LP) begin
                    p = '{ok: 1'b1, len: 2'd3, rhs0: SYM_RP, rhs1: SYM_E, rhs2: SYM_LP};
                end
            end
            default: begin
                p.ok = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/ll1ep_ram.sv =====
// ll1ep_ram: generic single write port, single read port ram with registered read
// no dependencies

module ll1ep_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ll1_expression_parser_core.sv =====
// ll1_expression_parser_core: table-driven ll(1) recognizer for the expression grammar
// depends on ll1ep_pkg and ll1ep_ram
//
//  channel  | dir | signals                        | contents
//  s_axis   | in  | tvalid tready tdata[7:0] tlast | ch, tlast = last byte of expression
//  m_axis   | out | tvalid tready tdata[7:0]       | verdict, error_kind
//
// a byte passes idle, then an eval step per expansion, a wr2 step per three-symbol
// production and an eval and a pop step per stack pop (match or empty production),
// then fin and result; the last byte adds the end-marker steps; the pop step waits
// on the registered read of the stack ram; spaces and bytes after a failure skip eval.
// reset is synchronous; entry 0 of the stack is fixed as the end marker and every other
// entry is written before it is read, so there is no clearing pass.
// a new input transaction is taken while a finished result waits on m_axis.

module ll1_expression_parser_core
    import ll1ep_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] verdict, [3:2] error_kind, [7:4] zero
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam logic [SP_W:0] DEPTH_X = (SP_W + 1)'(STACK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WR2,
        ST_POP,
        ST_FIN,
        ST_RESULT
    } t_state;

    t_state            r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    t_sym              r_top, n_top;
    t_sym              r_tok, n_tok;
    t_sym              r_pend, n_pend;
    logic              r_last, n_last;
    logic              r_end_phase, n_end_phase;
    logic              r_accepted, n_accepted;
    logic              r_matched, n_matched;
    logic              r_rd_zero, n_rd_zero;
    logic              r_failed, n_failed;
    t_err              r_code, n_code;
    logic              r_out_valid, n_out_valid;
    t_verdict          r_verdict, n_verdict;
    t_err              r_kind, n_kind;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [3:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [3:0]        mem_rdata;

    t_prod             prod;
    logic [SP_W:0]     need_sp;

    ll1ep_ram #(
        .WIDTH (4),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign prod    = lookup(r_top, r_tok);
    assign need_sp = {1'b0, r_sp} - (SP_W + 1)'(1) + (SP_W + 1)'(prod.len);

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        n_tok       = r_tok;
        n_pend      = r_pend;
        n_last      = r_last;
        n_end_phase = r_end_phase;
        n_accepted  = r_accepted;
        n_matched   = r_matched;
        n_rd_zero   = r_rd_zero;
        n_failed    = r_failed;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_verdict   = r_verdict;
        n_kind      = r_kind;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(r_sp - SP_W'(1));
        mem_wdata   = prod.rhs0;
        mem_raddr   = ADDR_W'(r_sp - SP_W'(2));

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_last      = i_s_axis_tlast;
                    n_end_phase = 1'b0;
                    n_accepted  = 1'b0;
                    if (!r_failed && i_s_axis_tdata != CH_SPACE) begin
                        n_tok   = classify(i_s_axis_tdata);
                        n_state = ST_EVAL;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_EVAL: begin
                priority if (r_top == SYM_END && r_tok == SYM_END) begin
                    n_accepted = 1'b1;
                    n_state    = ST_FIN;
                end else if (!is_nonterm(r_top)) begin
                    if (r_top == r_tok) begin
                        n_sp      = r_sp - SP_W'(1);
                        n_rd_zero = (r_sp == SP_W'(2));
                        n_matched = 1'b1;
                        n_state   = ST_POP;
                    end else begin
                        n_failed = 1'b1;
                        n_code   = ERR_MISMATCH;
                        n_state  = ST_FIN;
                    end
                end else if (!prod.ok) begin
                    n_failed = 1'b1;
                    n_code   = ERR_EMPTY;
                    n_state  = ST_FIN;
                end else if (need_sp > DEPTH_X) begin
                    n_failed = 1'b1;
                    n_code   = ERR_OVERFLOW;
                    n_state  = ST_FIN;
                end else begin
                    unique case (prod.len)
                        2'd0: begin
                            n_sp      = r_sp - SP_W'(1);
                            n_rd_zero = (r_sp == SP_W'(2));
                            n_matched = 1'b0;
                            n_state   = ST_POP;
                        end
                        2'd1: begin
                            n_top = prod.rhs0;
                        end
                        2'd2: begin
                            mem_we = 1'b1;
                            n_sp   = r_sp + SP_W'(1);
                            n_top  = prod.rhs1;
                        end
                        2'd3: begin
                            mem_we  = 1'b1;
                            n_sp    = r_sp + SP_W'(2);
                            n_pend  = prod.rhs1;
                            n_top   = prod.rhs2;
                            n_state = ST_WR2;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_sp - SP_W'(2));
                mem_wdata = r_pend;
                n_state   = ST_EVAL;
            end
            ST_POP: begin
                n_top   = r_rd_zero ? SYM_END : t_sym'(mem_rdata);
                n_state = r_matched ? ST_FIN : ST_EVAL;
            end
            ST_FIN: begin
                if (r_last && !r_end_phase && !r_failed) begin
                    n_tok       = SYM_END;
                    n_end_phase = 1'b1;
                    n_state     = ST_EVAL;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (!r_last) begin
                        n_verdict = VERDICT_BUSY;
                        n_kind    = r_code;
                    end else begin
                        n_verdict = r_accepted ? VERDICT_ACCEPT : VERDICT_REJECT;
                        n_kind    = r_accepted ? ERR_NONE : r_code;
                        n_sp      = SP_W'(2);
                        n_top     = SYM_E;
                        n_failed  = 1'b0;
                        n_code    = ERR_NONE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= SP_W'(2);
            r_top       <= SYM_E;
            r_failed    <= 1'b0;
            r_code      <= ERR_NONE;
            r_out_valid <= 1'b0;
            r_end_phase <= 1'b0;
            r_accepted  <= 1'b0;
            r_matched   <= 1'b0;
            r_rd_zero   <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_top       <= n_top;
            r_failed    <= n_failed;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
            r_end_phase <= n_end_phase;
            r_accepted  <= n_accepted;
            r_matched   <= n_matched;
            r_rd_zero   <= n_rd_zero;
            r_last      <= n_last;
        end
        r_tok     <= n_tok;
        r_pend    <= n_pend;
        r_verdict <= n_verdict;
        r_kind    <= n_kind;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_kind, r_verdict};

endmodule

// ===== hw/rtl/ll1ep_checker.sv =====
// ll1ep_checker: port-level assertions for the expression parser core
// depends on ll1ep_pkg; bound to ll1_expression_parser_core below

module ll1ep_checker
    import ll1ep_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // stalled result keeps valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a taken input transaction is followed by a busy cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken on consecutive cycles");

    // an accepted expression carries no error code
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == VERDICT_ACCEPT |->
            o_m_axis_tdata[3:2] == ERR_NONE)
        else $error("accept with error code");

    // a rejection always names its cause
    a_reject_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == VERDICT_REJECT |->
            o_m_axis_tdata[3:2] != ERR_NONE)
        else $error("reject without error code");

    // padding bits and the unused verdict code never appear
    a_out_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:4] == 4'b0000 && o_m_axis_tdata[1:0] != 2'b11)
        else $error("malformed result");

endmodule

bind ll1_expression_parser_core ll1ep_checker u_ll1ep_checker (.*);

// ===== tb/sv/ll1_expression_parser_core_tb.sv =====
// ll1_expression_parser_core_tb: self-checking bench for the ll(1) expression parser core
// a directed table, then random well-formed, broken and noise expressions, are checked
// against a bench model, typed rows by their listed result; uses ll1ep_pkg and the core

module ll1_expression_parser_core_tb;
    import ll1ep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int N_BYTES    = 1550;
    localparam int STALL_MAX  = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int DIR_N      = 24;

    typedef struct packed {
        t_err     err;
        t_verdict verdict;
    } t_res;

    typedef struct packed {
        logic [7:0] ch;
        bit         lst;
        bit         typed;
        t_res       res;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;  // [7:0] ch
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [1:0] verdict, [3:2] error_kind, [7:4] zero

    ll1_expression_parser_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // parser model state
    t_sym pstack [DEPTH];
    int   psp;
    bit   pfailed;
    t_err pcode;

    t_res       verdict_q [$];
    logic [7:0] expr_buf [$];
    int         n_sent, n_expr, n_fail;
    int         n_accept, n_mismatch, n_empty, n_overflow;
    int         tx_idle_pct = 18;
    int         rx_idle_pct = 58;
    bit         hold_req = 1'b0;

    t_dir_row dir_tab [DIR_N] = '{
        '{"a",      1'b1, 1'b1, '{ERR_NONE,     VERDICT_ACCEPT}},
        '{"(",      1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{"$",      1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{CH_SPACE, 1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{8'h00,    1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{8'hFF,    1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{"(",      1'b0, 1'b1, '{ERR_NONE,     VERDICT_BUSY}},
        '{"a",      1'b1, 1'b1, '{ERR_MISMATCH, VERDICT_REJECT}},
        '{"a",      1'b0, 1'b1, '{ERR_NONE,     VERDICT_BUSY}},
        '{")",      1'b0, 1'b1, '{ERR_MISMATCH, VERDICT_BUSY}},
        '{"b",      1'b1, 1'b1, '{ERR_MISMATCH, VERDICT_REJECT}},
        '{"Z",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"+",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"z",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"*",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"(",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"A",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{")",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{CH_SPACE, 1'b1, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"+",      1'b1, 1'b1, '{ERR_EMPTY,    VERDICT_REJECT}},
        '{"a",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"*",      1'b1, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"a",      1'b0, 1'b0, '{ERR_NONE,     VERDICT_BUSY}},
        '{"a",      1'b1, 1'b0, '{ERR_NONE,     VERDICT_BUSY}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void parser_reset();
        foreach (pstack[i]) pstack[i] = SYM_END;
        pstack[1] = SYM_E;
        psp       = 2;
        pfailed   = 1'b0;
        pcode     = ERR_NONE;
    endfunction

    function automatic void parser_fail(input t_err code);
        pfailed = 1'b1;
        pcode   = code;
    endfunction

    function automatic t_sym token_of(input logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return SYM_ID;
        case (c)
            CH_PLUS: return SYM_PLUS;
            CH_STAR: return SYM_STAR;
            CH_LP:   return SYM_LP;
            CH_RP:   return SYM_RP;
            default: return SYM_BAD;
        endcase
    endfunction

    // expands and pops until the token is matched or the parse fails; returns 1 on acceptance
    function automatic bit parse_token(input t_sym tok);
        t_sym top;
        t_sym rhs [3];
        int   n;
        while (!pfailed) begin
            if (psp == 0 || psp > DEPTH) begin
                parser_fail(ERR_MISMATCH);
                return 1'b0;
            end
            top = pstack[psp-1];
            if (top == SYM_END && tok == SYM_END) return 1'b1;
            if (!(top inside {SYM_E, SYM_EP, SYM_T, SYM_TP, SYM_F})) begin
                if (top == tok) begin
                    psp--;
                    return 1'b0;
                end
                parser_fail(ERR_MISMATCH);
                return 1'b0;
            end
            n = -1;
            case (top)
                SYM_E: begin
                    if (tok == SYM_ID || tok == SYM_LP) begin
                        n = 2; rhs[0] = SYM_EP; rhs[1] = SYM_T;
                    end
                end
                SYM_EP: begin
                    if (tok == SYM_PLUS) begin
                        n = 3; rhs[0] = SYM_EP; rhs[1] = SYM_T; rhs[2] = SYM_PLUS;
                    end else if (tok == SYM_RP || tok == SYM_END) begin
                        n = 0;
                    end
                end
                SYM_T: begin
                    if (tok == SYM_ID || tok == SYM_LP) begin
                        n = 2; rhs[0] = SYM_TP; rhs[1] = SYM_F;
                    end
                end
                SYM_TP: begin
                    if (tok == SYM_STAR) begin
                        n = 3; rhs[0] = SYM_TP; rhs[1] = SYM_F; rhs[2] = SYM_STAR;
                    end else if (tok == SYM_PLUS || tok == SYM_RP || tok == SYM_END) begin
                        n = 0;
                    end
                end
                default: begin
                    if (tok == SYM_ID) begin
                        n = 1; rhs[0] = SYM_ID;
                    end else if (tok == SYM_LP) begin
                        n = 3; rhs[0] = SYM_RP; rhs[1] = SYM_E; rhs[2] = SYM_LP;
                    end
                end
            endcase
            if (n < 0) begin
                parser_fail(ERR_EMPTY);
                return 1'b0;
            end
            if (psp - 1 + n > DEPTH) begin
                parser_fail(ERR_OVERFLOW);
                return 1'b0;
            end
            psp--;
            for (int i = 0; i < n; i++) begin
                pstack[psp] = rhs[i];
                psp++;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_verdict(input logic [7:0] c, input bit lst);
        bit   acc;
        t_res r;
        acc = 1'b0;
        if (!pfailed && c != CH_SPACE) void'(parse_token(token_of(c)));
        if (!lst) begin
            r = '{pcode, VERDICT_BUSY};
        end else begin
            if (!pfailed) acc = parse_token(SYM_END);
            r = acc ? t_res'{ERR_NONE, VERDICT_ACCEPT} : t_res'{pcode, VERDICT_REJECT};
            parser_reset();
        end
        return r;
    endfunction

    // expression text generation
    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic void put_char(input logic [7:0] c);
        if ($urandom_range(0, 9) == 0) expr_buf = {expr_buf, CH_SPACE};
        expr_buf = {expr_buf, c};
    endfunction

    function automatic void gen_factor(input int lvl);
        if (lvl < 4 && $urandom_range(0, 3) == 0) begin
            put_char(CH_LP);
            gen_sum(lvl + 1);
            put_char(CH_RP);
        end else begin
            put_char(rand_letter());
        end
    endfunction

    function automatic void gen_term(input int lvl);
        gen_factor(lvl);
        repeat ($urandom_range(0, 2)) begin
            put_char(CH_STAR);
            gen_factor(lvl);
        end
    endfunction

    function automatic void gen_sum(input int lvl);
        gen_term(lvl);
        repeat ($urandom_range(0, 2)) begin
            put_char(CH_PLUS);
            gen_term(lvl);
        end
    endfunction

    function automatic void gen_nest(input int k);
        repeat (k) put_char(CH_LP);
        put_char(rand_letter());
        repeat (k) put_char(CH_RP);
    endfunction

    function automatic void build_expr();
        logic [7:0] junk [6];
        int         r, pos;
        junk = '{CH_PLUS, CH_STAR, CH_LP, CH_RP, CH_SPACE, "a"};
        expr_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 6) begin
            gen_nest($urandom_range(15, 24));
        end else if (r < 16) begin
            repeat ($urandom_range(1, 8)) expr_buf = {expr_buf, 8'($urandom_range(0, 255))};
        end else begin
            gen_sum(0);
            if ($urandom_range(0, 99) < 25) begin
                pos = $urandom_range(0, expr_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0: expr_buf[pos] = 8'($urandom_range(0, 255));
                    1: expr_buf[pos] = junk[$urandom_range(0, 5)];
                    2: if (expr_buf.size() > 1) expr_buf.delete(pos);
                    default: while (expr_buf.size() > pos + 1) void'(expr_buf.pop_back());
                endcase
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit lst, input bit typed,
                             input t_res typed_res);
        t_res p;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        p = predict_verdict(c, lst);
        if (typed) p = typed_res;
        verdict_q = {verdict_q, p};
        n_sent++;
        if (lst) begin
            n_expr++;
            if (p.verdict == VERDICT_ACCEPT) n_accept++;
            else if (p.err == ERR_MISMATCH) n_mismatch++;
            else if (p.err == ERR_EMPTY) n_empty++;
            else if (p.err == ERR_OVERFLOW) n_overflow++;
        end
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_buf.size(); i++) begin
            send_byte(expr_buf[i], i == expr_buf.size() - 1, 1'b0, '0);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, o_m_axis_tdata);
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                if (o_m_axis_tdata[1:0] != want.verdict) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, want.verdict, o_m_axis_tdata[1:0]);
                    n_fail++;
                end
                if (o_m_axis_tdata[3:2] != want.err) begin
                    $display("%0t: error_kind mismatch, expected %0d, actual %0d",
                             $time, want.err, o_m_axis_tdata[3:2]);
                    n_fail++;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall = 0;
            else
                stall++;
            if (stall >= STALL_MAX) begin
                $display("%0t: no transaction for %0d cycles", $time, stall);
                $display("ll1_expression_parser_core test failed");
                $finish;
            end
        end
    end

    initial begin
        int pace;
        parser_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            send_byte(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].res);
        end

        // nesting deep enough to overflow the symbol stack
        expr_buf.delete();
        gen_nest(22);
        send_expr();

        while (n_sent < N_BYTES) begin
            pace = (n_sent * 3) / N_BYTES;
            if (pace == 1) begin
                tx_idle_pct = 58;
                rx_idle_pct = 18;
            end else if (pace >= 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            build_expr();
            send_expr();
        end
        i_s_axis_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes in %0d expressions, %0d accepted", n_sent, n_expr, n_accept);
        $display("rejected: %0d terminal mismatch, %0d empty entry, %0d stack overflow",
                 n_mismatch, n_empty, n_overflow);
        if (n_fail == 0) begin
            $display("ll1_expression_parser_core test passed");
        end else begin
            $display("ll1_expression_parser_core test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ll1ep_pkg.sv
hw/rtl/ll1ep_ram.sv
hw/rtl/ll1_expression_parser_core.sv
hw/rtl/ll1ep_checker.sv
tb/sv/ll1_expression_parser_core_tb.sv
